// ===== design/rpn_pkg.sv =====
// Shared widths, token and status codes, and divider handshake types.
`default_nettype none
package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int TYPE_W          = 3;
  localparam int DIGIT_W         = 4;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 6;
  localparam int STACK_DEPTH_DEF = 32;

  // token kinds
  localparam logic [TYPE_W-1:0] TOK_DIGIT = 3'd0;
  localparam logic [TYPE_W-1:0] TOK_ADD   = 3'd1;
  localparam logic [TYPE_W-1:0] TOK_SUB   = 3'd2;
  localparam logic [TYPE_W-1:0] TOK_MUL   = 3'd3;
  localparam logic [TYPE_W-1:0] TOK_DIV   = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/rpn_stack_ram.sv =====
// Operand stack storage: one write port, one registered read port.
`default_nettype none
module rpn_stack_ram
  import rpn_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/rpn_divider.sv =====
// Signed 32-bit divider, truncating toward zero; one quotient bit per cycle.
`default_nettype none
module rpn_divider
  import rpn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int ITER_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic              neg_r;
  logic [DATA_W-1:0] dm_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              borrow;

  // rem < divisor <= 2^31, so the shifted remainder never reaches bit DATA_W
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dm_r};
  assign borrow  = diff[DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        iter_r <= '0;
        neg_r  <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
        dm_r   <= req.den[DATA_W-1] ? (DATA_W'(0) - req.den) : req.den;
        quo_r  <= req.num[DATA_W-1] ? (DATA_W'(0) - req.num) : req.num;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= borrow ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
        quo_r  <= {quo_r[DATA_W-2:0], ~borrow};
        iter_r <= iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule
`default_nettype wire

// ===== design/rpn_stack_evaluator.sv =====
// Top level: RPN token sequencer around the stack memory and the divider.
// Digits, ignored tokens and too-few-operand errors finish from S_DECODE;
// add, subtract, multiply and a zero divisor go on through S_OPER; a divide
// also waits in S_DIV for the one-bit-per-cycle divider (32 steps).
// One token at a time: in_stall holds until S_IDLE is reached again, later
// while the output is stalled. Reset (sync, active low) empties the stack;
// stack memory contents stay undefined and no clearing pass is run.
`default_nettype none
module rpn_stack_evaluator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [TYPE_W-1:0]   in_req_type,
  input  wire logic        [DIGIT_W-1:0]  in_digit_value,
  input  wire logic                       in_start_new,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic             [STATUS_W-1:0] out_status,
  output logic signed      [DATA_W-1:0]   out_top_value,
  output logic             [DEPTH_W-1:0]  out_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_DIV,
    S_FINISH
  } state_t;

  state_t              state_r;
  logic [TYPE_W-1:0]   kind_r;
  logic [DIGIT_W-1:0]  digit_r;
  logic [CW-1:0]       cnt_r;      // entries on the stack
  logic [DATA_W-1:0]   top_r;      // copy of entry cnt_r-1
  logic [STATUS_W-1:0] status_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_top_r;
  logic [DEPTH_W-1:0]  out_depth_r;

  logic                in_xfer;
  logic                out_free;
  logic                stack_full;
  logic                few_ops;
  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       cnt_m2;
  logic [DATA_W-1:0]   left_op;
  logic [DATA_W-1:0]   alu_res;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;

  assign stack_full = (cnt_r == CW'(STACK_DEPTH));
  assign few_ops    = (cnt_r < CW'(2));
  assign cnt_m1     = cnt_r - CW'(1);
  assign cnt_m2     = cnt_r - CW'(2);

  // Left operand sits below the cached top; read issued in S_DECODE,
  // data valid in S_OPER. Only one token is in flight, so every write
  // lands before the next read is issued and no forwarding is needed.
  assign ram_re = (state_r == S_DECODE);

  rpn_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (left_op)
  );

  // right operand is the cached top
  always_comb begin
    case (kind_r)
      TOK_ADD: alu_res = left_op + top_r;
      TOK_SUB: alu_res = left_op - top_r;
      TOK_MUL: alu_res = DATA_W'(left_op * top_r);
      default: alu_res = left_op;
    endcase
  end

  always_comb begin
    div_req.start = (state_r == S_OPER) && (kind_r == TOK_DIV) && (top_r != '0);
    div_req.num   = left_op;
    div_req.den   = top_r;
  end

  rpn_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // stack write port: push a digit, or replace the left operand by a result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_m2[AW-1:0];
    ram_wdata = alu_res;
    unique case (state_r)
      S_DECODE: begin
        if (kind_r == TOK_DIGIT && !stack_full) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
          ram_wdata = DATA_W'(digit_r);
        end
      end
      S_OPER: begin
        if (kind_r == TOK_ADD || kind_r == TOK_SUB || kind_r == TOK_MUL) begin
          ram_we = 1'b1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = div_rsp.quot;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load a new result, or drop the one just taken
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            kind_r  <= in_req_type;
            digit_r <= in_digit_value;
            if (in_start_new) begin
              cnt_r <= '0;
            end
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (kind_r)
            TOK_DIGIT: begin
              state_r <= S_FINISH;
              if (stack_full) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_OK;
                top_r    <= DATA_W'(digit_r);
                cnt_r    <= cnt_r + CW'(1);
              end
            end
            TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
              if (few_ops) begin
                status_r <= ST_FEW;
                state_r  <= S_FINISH;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_OPER;
              end
            end
            default: begin
              status_r <= ST_OK;   // unknown token: no change
              state_r  <= S_FINISH;
            end
          endcase
        end
        S_OPER: begin
          if (kind_r == TOK_DIV) begin
            if (top_r == '0) begin
              // divisor popped, left operand becomes the top
              status_r <= ST_DIVZERO;
              top_r    <= left_op;
              cnt_r    <= cnt_m1;
              state_r  <= S_FINISH;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            top_r   <= alu_res;
            cnt_r   <= cnt_m1;
            state_r <= S_FINISH;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            top_r   <= div_rsp.quot;
            cnt_r   <= cnt_m1;
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_top_r    <= (cnt_r != '0) ? top_r : '0;
            out_depth_r  <= DEPTH_W'(cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = $signed(out_top_r);
  assign out_depth     = out_depth_r;

  // stack never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // a divider result only arrives while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider done outside divide wait");

  // full status is reported only with a full stack
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free && status_r == ST_FULL)
      |=> out_depth == DEPTH_W'(STACK_DEPTH))
    else $error("stack full status with stack not full");

  // too few operands means fewer than two entries after the step
  a_few_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free && status_r == ST_FEW) |=> out_depth < DEPTH_W'(2))
    else $error("too-few status with two or more entries");

endmodule
`default_nettype wire

// ===== tb/sv/tb_rpn_stack_evaluator.sv =====
// Self-checking testbench for the RPN stack evaluator: directed table, then random sequences.
`timescale 1ns / 100ps
module tb_rpn_stack_evaluator
  import rpn_pkg::*;
;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;

  // Codes 5..7 are not tokens; the block drops them without touching the stack.
  localparam logic [TYPE_W-1:0] TOK_NOP_5 = 3'd5;
  localparam logic [TYPE_W-1:0] TOK_NOP_6 = 3'd6;
  localparam logic [TYPE_W-1:0] TOK_NOP_7 = 3'd7;

  localparam int RANDOM_TOKENS = 1850;  // stop point for random stimulus
  localparam int CALM_TAIL     = 200;   // last stretch runs with no idling
  localparam int DRAIN_CYCLES  = 50;    // longer than the divide latency
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [DIGIT_W-1:0] digit;
    logic               start_new;
  } rpn_token_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_W-1:0]       depth;
  } rpn_result_t;

  typedef struct packed {
    rpn_token_t  tok;
    logic        typed;     // expected result written into the row
    rpn_result_t want;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic        [TYPE_W-1:0]   in_req_type;
  logic        [DIGIT_W-1:0]  in_digit_value;
  logic                       in_start_new;
  logic                       out_valid;
  logic                       out_stall;
  logic        [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0]   out_top_value;
  logic        [DEPTH_W-1:0]  out_depth;

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_digit_value(in_digit_value),
    .in_start_new  (in_start_new),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth)
  );

  // 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the operand stack, advanced once per accepted transfer.
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_depth;

  rpn_result_t pending_results [$];   // expected results, oldest first
  dir_row_t    dir_rows [$];
  int          mismatches;
  int          tokens_sent;
  bit          in_idle_on;
  bit          out_idle_on;
  int          stall_left;

  // Apply one token to the shadow stack and return the result it should produce.
  function automatic rpn_result_t eval_token(input rpn_token_t t);
    rpn_result_t       r;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] nmag;
    logic [DATA_W-1:0] dmag;
    logic [DATA_W-1:0] qmag;
    r.status = ST_OK;
    if (t.start_new) shadow_depth = 0;
    case (t.kind)
      TOK_DIGIT: begin
        // full stack: push is dropped
        if (shadow_depth >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_stack[shadow_depth] = DATA_W'(t.digit);
          shadow_depth++;
        end
      end
      TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
        if (shadow_depth < 2) begin
          r.status = ST_FEW;          // stack left alone
        end else begin
          rhs = shadow_stack[shadow_depth - 1];
          shadow_depth--;
          if (t.kind == TOK_DIV && rhs == '0) begin
            r.status = ST_DIVZERO;    // divisor stays popped
          end else begin
            lhs = shadow_stack[shadow_depth - 1];
            shadow_depth--;
            case (t.kind)
              TOK_ADD: res = lhs + rhs;
              TOK_SUB: res = lhs - rhs;
              TOK_MUL: res = lhs * rhs;
              default: begin
                // truncate toward zero via magnitudes; min / -1 wraps
                nmag = lhs[DATA_W-1] ? -lhs : lhs;
                dmag = rhs[DATA_W-1] ? -rhs : rhs;
                qmag = nmag / dmag;
                res  = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -qmag : qmag;
              end
            endcase
            shadow_stack[shadow_depth] = res;
            shadow_depth++;
          end
        end
      end
      default: ;                      // ignored token
    endcase
    r.top   = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
    r.depth = DEPTH_W'(shadow_depth);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Present one token and hold it until the transfer happens; queue its result.
  task automatic send_token(input logic [TYPE_W-1:0] kind, input logic [DIGIT_W-1:0] digit,
                            input logic start_new, input logic typed = 1'b0,
                            input rpn_result_t want = '0);
    rpn_token_t  t;
    rpn_result_t predicted;
    t.kind      = kind;
    t.digit     = digit;
    t.start_new = start_new;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_digit_value <= digit;
    in_start_new   <= start_new;
    do @(posedge clk); while (in_stall);
    predicted = eval_token(t);
    pending_results.push_back(typed ? want : predicted);
    tokens_sent++;
  endtask

  task automatic add_row(input logic [TYPE_W-1:0] kind, input logic [DIGIT_W-1:0] digit,
                         input logic start_new, input logic typed = 1'b0,
                         input logic [STATUS_W-1:0] st = ST_OK, input int top = 0,
                         input int dep = 0);
    dir_row_t row;
    row.tok.kind      = kind;
    row.tok.digit     = digit;
    row.tok.start_new = start_new;
    row.typed         = typed;
    row.want.status   = st;
    row.want.top      = top;
    row.want.depth    = DEPTH_W'(dep);
    dir_rows.push_back(row);
  endtask

  function automatic logic [DIGIT_W-1:0] rand_digit();
    // mostly decimal digits, now and then the out-of-range codes
    return ($urandom_range(0, 7) == 0) ? DIGIT_W'($urandom_range(10, 15))
                                       : DIGIT_W'($urandom_range(0, 9));
  endfunction

  // Receiver side: stall in bursts whose length is drawn at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Result checker: every transfer on the output side against the oldest expectation.
  always @(posedge clk) begin
    rpn_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d top %0d depth %0d",
                                  out_status, out_top_value, out_depth));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_top_value !== want.top ||
            out_depth !== want.depth) begin
          report_mismatch($sformatf(
            "result mismatch: status %0d/%0d top %0d/%0d depth %0d/%0d (exp/act)",
            want.status, out_status, want.top, out_top_value, want.depth, out_depth));
        end
      end
    end
  end

  initial begin
    int shape;
    int len;
    logic [TYPE_W-1:0] kind;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= TOK_DIGIT;
    in_digit_value <= '0;
    in_start_new   <= 1'b0;
    shadow_depth   = 0;
    mismatches     = 0;
    tokens_sent    = 0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed rows come straight from the token semantics,
    // the rest go through the predictor.
    add_row(TOK_ADD,   4'd0,  1'b0, 1'b1, ST_FEW,     0,  0);  // operator on empty stack
    add_row(TOK_DIGIT, 4'd9,  1'b0, 1'b1, ST_OK,      9,  1);
    add_row(TOK_DIV,   4'd0,  1'b0, 1'b1, ST_FEW,     9,  1);  // one operand only
    add_row(TOK_DIGIT, 4'd0,  1'b0, 1'b1, ST_OK,      0,  2);
    add_row(TOK_DIV,   4'd0,  1'b0, 1'b1, ST_DIVZERO, 9,  1);  // zero divisor popped
    add_row(TOK_DIGIT, 4'd15, 1'b0, 1'b1, ST_OK,      15, 2);  // out-of-range digit
    add_row(TOK_SUB,   4'd0,  1'b0);                           // 9 - 15
    add_row(TOK_DIGIT, 4'd7,  1'b0);
    add_row(TOK_MUL,   4'd0,  1'b0);
    add_row(TOK_DIGIT, 4'd4,  1'b0);
    add_row(TOK_DIV,   4'd0,  1'b0);                           // negative, truncates
    add_row(TOK_DIGIT, 4'd3,  1'b0);
    add_row(TOK_ADD,   4'd0,  1'b0);
    add_row(TOK_NOP_5, 4'd5,  1'b0);
    add_row(TOK_NOP_6, 4'd10, 1'b0);
    add_row(TOK_NOP_7, 4'd15, 1'b0);
    add_row(TOK_NOP_7, 4'd0,  1'b1, 1'b1, ST_OK,      0,  0);  // start clears, then ignored
    add_row(TOK_DIGIT, 4'd0,  1'b1, 1'b1, ST_OK,      0,  1);
    add_row(TOK_ADD,   4'd0,  1'b1, 1'b1, ST_FEW,     0,  0);  // start leaves too few
    add_row(TOK_DIGIT, 4'd8,  1'b0);
    add_row(TOK_DIGIT, 4'd3,  1'b0);
    add_row(TOK_SUB,   4'd0,  1'b0);
    add_row(TOK_DIGIT, 4'd9,  1'b1, 1'b1, ST_OK,      9,  1);
    foreach (dir_rows[i]) begin
      send_token(dir_rows[i].tok.kind, dir_rows[i].tok.digit, dir_rows[i].tok.start_new,
                 dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: mostly well-formed expressions, plus stack fills, the
    // most negative quotient, and unconstrained noise.
    while (tokens_sent < RANDOM_TOKENS) begin
      if (tokens_sent >= RANDOM_TOKENS - CALM_TAIL) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else begin
        in_idle_on  = ($urandom_range(0, 4) != 0);
        out_idle_on = ($urandom_range(0, 4) != 0);
      end
      shape = $urandom_range(0, 99);
      if (shape < 60) begin
        // expression on a fresh stack; ops only where two operands exist
        len = $urandom_range(3, 20);
        send_token(TOK_DIGIT, rand_digit(), 1'b1);
        repeat (len) begin
          if (shadow_depth < 2 ||
              (shadow_depth < STACK_DEPTH - 1 && $urandom_range(0, 1) == 0)) begin
            send_token(TOK_DIGIT, rand_digit(), 1'b0);
          end else begin
            send_token(TYPE_W'($urandom_range(TOK_ADD, TOK_DIV)), rand_digit(), 1'b0);
          end
        end
      end else if (shape < 70) begin
        // fill to the top and push past it, then fold a little
        send_token(TOK_DIGIT, rand_digit(), 1'b1);
        repeat (STACK_DEPTH + $urandom_range(0, 3)) begin
          send_token(TOK_DIGIT, DIGIT_W'($urandom_range(0, 15)), 1'b0);
        end
        repeat ($urandom_range(1, 8)) begin
          send_token(TYPE_W'($urandom_range(TOK_ADD, TOK_DIV)), rand_digit(), 1'b0);
        end
      end else if (shape < 78) begin
        // 8^10 * 2 wraps to the most negative value, then divide it
        send_token(TOK_DIGIT, 4'd8, 1'b1);
        repeat (9) send_token(TOK_DIGIT, 4'd8, 1'b0);
        repeat (9) send_token(TOK_MUL, 4'd0, 1'b0);
        send_token(TOK_DIGIT, 4'd2, 1'b0);
        send_token(TOK_MUL, 4'd0, 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          send_token(TOK_DIGIT, 4'd0, 1'b0);
          send_token(TOK_DIGIT, 4'd1, 1'b0);
          send_token(TOK_SUB, 4'd0, 1'b0);       // -1
        end else begin
          send_token(TOK_DIGIT, DIGIT_W'($urandom_range(0, 15)), 1'b0);
        end
        send_token(TOK_DIV, 4'd0, 1'b0);
      end else begin
        // noise: any code, any digit, occasional start
        repeat ($urandom_range(1, 10)) begin
          kind = TYPE_W'($urandom_range(0, 7));
          send_token(kind, DIGIT_W'($urandom_range(0, 15)), ($urandom_range(0, 7) == 0));
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
design/rpn_pkg.sv
design/rpn_stack_ram.sv
design/rpn_divider.sv
design/rpn_stack_evaluator.sv
tb/sv/tb_rpn_stack_evaluator.sv
